[rtl/tsni_pkg.sv]
// Shared types and constants for the TLS SNI host name extractor.
package tsni_pkg;

  localparam int POSITION_BITS_DEFAULT = 17;
  localparam int RESULT_DEPTH          = 4;
  localparam int RESULT_IDX_BITS       = $clog2(RESULT_DEPTH);

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_FOUND      = 2'd0;
  localparam verdict_t VERDICT_INCOMPLETE = 2'd1;
  localparam verdict_t VERDICT_NONAME     = 2'd2;
  localparam verdict_t VERDICT_MALFORMED  = 2'd3;

  localparam logic RESULT_KIND_NAME    = 1'b0;
  localparam logic RESULT_KIND_VERDICT = 1'b1;

  localparam logic [7:0] TLS_HANDSHAKE    = 8'h16;
  localparam logic [7:0] HS_CLIENT_HELLO  = 8'h01;
  localparam logic [7:0] SSL2_HELLO_MARK  = 8'h80;
  localparam logic [7:0] SSL2_CLIENT_HELLO = 8'h01;
  localparam logic [7:0] NAME_TYPE_HOST   = 8'h00;
  localparam int         HELLO_FIXED_SKIP = 37;
  localparam int         RECORD_HDR_BYTES = 5;

  // What one accepted byte produces: an optional name byte and an optional verdict.
  typedef struct packed {
    logic        name_valid;
    logic        verdict_valid;
    logic [7:0]  name_byte;
    verdict_t    verdict;
    logic [15:0] host_length;
  } parse_out_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_byte;
    verdict_t    verdict;
    logic [15:0] host_length;
    logic        last_of_run;
  } result_t;

endpackage

[rtl/tsni_if.sv]
// Stream interfaces for payload bytes in and results out.
interface tsni_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       end_of_payload;

  modport source (output valid, output payload_byte, output end_of_payload, input ready);
  modport sink   (input valid, input payload_byte, input end_of_payload, output ready);
endinterface

interface tsni_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  name_byte;
  logic [1:0]  verdict;
  logic [15:0] host_length;
  logic        last_of_run;

  modport source (output valid, output result_kind, output name_byte, output verdict,
                  output host_length, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input name_byte, input verdict,
                  input host_length, input last_of_run, output ready);
endinterface

[rtl/tsni_parser.sv]
// ClientHello walker: per-byte position tracking, field decode and verdict.
module tsni_parser #(
  parameter int PosBits = tsni_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  output tsni_pkg::parse_out_t res
);
  import tsni_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER, PH_SID_LEN, PH_CS_HI, PH_CS_LO, PH_COMP_LEN, PH_EXT_HI, PH_EXT_LO,
    PH_XT_HI, PH_XT_LO, PH_XL_HI, PH_XL_LO, PH_NT, PH_NL_HI, PH_NL_LO, PH_NAME, PH_HALT
  } phase_t;

  localparam logic [2:0] DEC_FOUND      = 3'd0;
  localparam logic [2:0] DEC_INCOMPLETE = 3'd1;
  localparam logic [2:0] DEC_NONAME     = 3'd2;
  localparam logic [2:0] DEC_MALFORMED  = 3'd3;
  localparam logic [2:0] DEC_UNDECIDED  = 3'd4;

  localparam int SW = PosBits + 1;

  phase_t             phase, phase_next;
  logic [PosBits-1:0] pos, pos_next;
  logic [PosBits-1:0] rec_end, rec_end_next;
  logic [PosBits-1:0] ext_end, ext_end_next;
  logic [PosBits-1:0] sni_end, sni_end_next;
  logic [PosBits-1:0] skip, skip_next;
  logic [7:0]         len_acc, len_acc_next;
  logic [15:0]        entry_rem, entry_rem_next;
  logic [7:0]         first_byte, first_byte_next;
  logic [7:0]         major, major_next;
  logic [7:0]         minor, minor_next;
  logic [2:0]         dec, dec_next;
  logic [15:0]        found_len, found_len_next;

  // scratch
  logic               emit;
  logic               do_goto;
  phase_t             g_ph;
  logic [15:0]        g_n;
  logic               do_dec;
  logic [2:0]         dec_v;
  logic [15:0]        len16;
  logic [SW-1:0]      t;
  logic [SW-1:0]      sum;
  logic [2:0]         v;

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    rec_end_next    = rec_end;
    ext_end_next    = ext_end;
    sni_end_next    = sni_end;
    skip_next       = skip;
    len_acc_next    = len_acc;
    entry_rem_next  = entry_rem;
    first_byte_next = first_byte;
    major_next      = major;
    minor_next      = minor;
    dec_next        = dec;
    found_len_next  = found_len;
    emit    = 1'b0;
    do_goto = 1'b0;
    g_ph    = PH_HEADER;
    g_n     = '0;
    do_dec  = 1'b0;
    dec_v   = DEC_MALFORMED;
    len16   = {len_acc, data_byte};
    t       = '0;
    sum     = {1'b0, pos + PosBits'(1)} + SW'(len16);
    v       = DEC_UNDECIDED;
    res     = '0;

    if (fire) begin
      if (pos < PosBits'(RECORD_HDR_BYTES) || pos < rec_end) begin
        pos_next = pos + PosBits'(1);
        if (phase != PH_HALT) begin
          if (skip != '0) begin
            skip_next = skip - PosBits'(1);
          end else begin
            unique case (phase)
              PH_HEADER: begin
                if (pos == PosBits'(0)) begin
                  first_byte_next = data_byte;
                end else if (pos == PosBits'(1)) begin
                  major_next = data_byte;
                end else if (pos == PosBits'(2)) begin
                  minor_next = data_byte;
                  if ((first_byte & SSL2_HELLO_MARK) != 8'h00 &&
                      data_byte == SSL2_CLIENT_HELLO) begin
                    do_dec = 1'b1; dec_v = DEC_NONAME;
                  end else if (first_byte != TLS_HANDSHAKE) begin
                    do_dec = 1'b1; dec_v = DEC_MALFORMED;
                  end else if (major < 8'd3) begin
                    do_dec = 1'b1; dec_v = DEC_NONAME;
                  end
                end else if (pos == PosBits'(3)) begin
                  len_acc_next = data_byte;
                end else if (pos == PosBits'(4)) begin
                  rec_end_next = PosBits'(len16) + PosBits'(RECORD_HDR_BYTES);
                  if (len16 == 16'd0) begin
                    do_dec = 1'b1; dec_v = DEC_MALFORMED;
                  end
                end else begin
                  if (data_byte != HS_CLIENT_HELLO) begin
                    do_dec = 1'b1; dec_v = DEC_MALFORMED;
                  end else begin
                    do_goto = 1'b1; g_ph = PH_SID_LEN; g_n = 16'(HELLO_FIXED_SKIP);
                  end
                end
              end
              PH_SID_LEN: begin
                do_goto = 1'b1; g_ph = PH_CS_HI; g_n = {8'h00, data_byte};
              end
              PH_CS_HI, PH_EXT_HI, PH_XL_HI, PH_NL_HI: begin
                len_acc_next = data_byte;
                phase_next   = phase_t'(phase + 4'd1);
              end
              PH_CS_LO: begin
                do_goto = 1'b1; g_ph = PH_COMP_LEN; g_n = len16;
              end
              PH_COMP_LEN: begin
                do_goto = 1'b1; g_ph = PH_EXT_HI; g_n = {8'h00, data_byte};
              end
              PH_EXT_LO: begin
                if (sum > {1'b0, rec_end}) begin
                  do_dec = 1'b1; dec_v = DEC_MALFORMED;
                end else begin
                  ext_end_next = sum[PosBits-1:0];
                  do_goto = 1'b1; g_ph = PH_XT_HI; g_n = '0;
                end
              end
              PH_XT_HI: begin
                entry_rem_next = {data_byte, 8'h00};
                phase_next     = PH_XT_LO;
              end
              PH_XT_LO: begin
                entry_rem_next = {entry_rem[15:8], data_byte};
                phase_next     = PH_XL_HI;
              end
              PH_XL_LO: begin
                if (entry_rem == 16'd0) begin
                  if (sum > {1'b0, ext_end}) begin
                    do_dec = 1'b1; dec_v = DEC_MALFORMED;
                  end else begin
                    sni_end_next = sum[PosBits-1:0];
                    do_goto = 1'b1; g_ph = PH_NT; g_n = 16'd2;
                  end
                end else begin
                  do_goto = 1'b1; g_ph = PH_XT_HI; g_n = len16;
                end
              end
              PH_NT: begin
                entry_rem_next = {8'h00, data_byte};
                phase_next     = PH_NL_HI;
              end
              PH_NL_LO: begin
                if (sum > {1'b0, sni_end}) begin
                  do_dec = 1'b1; dec_v = DEC_MALFORMED;
                end else if (entry_rem[7:0] != NAME_TYPE_HOST) begin
                  do_goto = 1'b1; g_ph = PH_NT; g_n = len16;
                end else if (len16 == 16'd0) begin
                  do_dec = 1'b1; dec_v = DEC_NONAME;
                end else begin
                  dec_next       = DEC_FOUND;
                  found_len_next = len16;
                  entry_rem_next = len16;
                  phase_next     = PH_NAME;
                end
              end
              PH_NAME: begin
                emit           = 1'b1;
                entry_rem_next = entry_rem - 16'd1;
                if (entry_rem == 16'd1) phase_next = PH_HALT;
              end
              default: ;
            endcase
          end
        end
      end

      // skip n bytes, then land on the next field if it can still fit
      if (do_goto) begin
        t = {1'b0, pos_next} + SW'(g_n);
        case (g_ph)
          PH_SID_LEN, PH_COMP_LEN: begin
            if (t + SW'(1) > {1'b0, rec_end_next}) begin do_dec = 1'b1; dec_v = DEC_MALFORMED; end
          end
          PH_CS_HI: begin
            if (t + SW'(2) > {1'b0, rec_end_next}) begin do_dec = 1'b1; dec_v = DEC_MALFORMED; end
          end
          PH_EXT_HI: begin
            if (t == {1'b0, rec_end_next} && major_next == 8'd3 && minor_next == 8'd0) begin
              do_dec = 1'b1; dec_v = DEC_NONAME;
            end else if (t + SW'(2) > {1'b0, rec_end_next}) begin
              do_dec = 1'b1; dec_v = DEC_MALFORMED;
            end
          end
          PH_XT_HI: begin
            if (t == {1'b0, ext_end_next}) begin
              do_dec = 1'b1; dec_v = DEC_NONAME;
            end else if (t + SW'(4) > {1'b0, ext_end_next}) begin
              do_dec = 1'b1; dec_v = DEC_MALFORMED;
            end
          end
          PH_NT: begin
            if (t == {1'b0, sni_end_next}) begin
              do_dec = 1'b1; dec_v = DEC_NONAME;
            end else if (t + SW'(3) > {1'b0, sni_end_next}) begin
              do_dec = 1'b1; dec_v = DEC_MALFORMED;
            end
          end
          default: ;
        endcase
        if (!do_dec) begin
          phase_next = g_ph;
          skip_next  = PosBits'(g_n);
        end
      end

      if (do_dec) begin
        dec_next   = dec_v;
        phase_next = PH_HALT;
      end

      res.name_valid = emit;
      res.name_byte  = data_byte;

      if (final_byte) begin
        if (pos_next < PosBits'(RECORD_HDR_BYTES)) begin
          v = DEC_INCOMPLETE;
        end else if (rec_end_next != '0 && pos_next < rec_end_next) begin
          v = DEC_INCOMPLETE;
        end else if (dec_next > DEC_MALFORMED) begin
          v = DEC_MALFORMED;
        end else begin
          v = dec_next;
        end
        res.verdict_valid = 1'b1;
        res.verdict       = v[1:0];
        res.host_length   = (v == DEC_FOUND) ? found_len_next : 16'd0;

        phase_next      = PH_HEADER;
        pos_next        = '0;
        rec_end_next    = '0;
        ext_end_next    = '0;
        sni_end_next    = '0;
        skip_next       = '0;
        len_acc_next    = '0;
        entry_rem_next  = '0;
        first_byte_next = '0;
        major_next      = '0;
        minor_next      = '0;
        dec_next        = DEC_UNDECIDED;
        found_len_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      pos        <= '0;
      rec_end    <= '0;
      ext_end    <= '0;
      sni_end    <= '0;
      skip       <= '0;
      len_acc    <= '0;
      entry_rem  <= '0;
      first_byte <= '0;
      major      <= '0;
      minor      <= '0;
      dec        <= DEC_UNDECIDED;
      found_len  <= '0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      rec_end    <= rec_end_next;
      ext_end    <= ext_end_next;
      sni_end    <= sni_end_next;
      skip       <= skip_next;
      len_acc    <= len_acc_next;
      entry_rem  <= entry_rem_next;
      first_byte <= first_byte_next;
      major      <= major_next;
      minor      <= minor_next;
      dec        <= dec_next;
      found_len  <= found_len_next;
    end
  end

endmodule

[rtl/tsni_result_fifo.sv]
// Result queue: takes up to two results per cycle, drives one beat per cycle while the sink is ready.
module tsni_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  tsni_pkg::parse_out_t push,
  output logic                 room,
  tsni_out_if.source           result
);
  import tsni_pkg::*;

  result_t                    entries [RESULT_DEPTH];
  logic [RESULT_IDX_BITS-1:0] wr_ptr, rd_ptr;
  logic [RESULT_IDX_BITS:0]   count, count_next;
  logic                       pop;
  logic [1:0]                 n_push;
  result_t                    name_res, verdict_res;

  assign pop    = result.valid && result.ready;
  assign n_push = 2'(push.name_valid) + 2'(push.verdict_valid);
  // room for the worst case of two results from one byte
  assign room   = count <= (RESULT_IDX_BITS+1)'(RESULT_DEPTH - 2);

  assign count_next = count + (RESULT_IDX_BITS+1)'(n_push) - (RESULT_IDX_BITS+1)'(pop);

  always_comb begin
    name_res             = '0;
    name_res.result_kind = RESULT_KIND_NAME;
    name_res.name_byte   = push.name_byte;
    verdict_res             = '0;
    verdict_res.result_kind = RESULT_KIND_VERDICT;
    verdict_res.verdict     = push.verdict;
    verdict_res.host_length = push.host_length;
    verdict_res.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push.name_valid) begin
      entries[wr_ptr] <= name_res;
      if (push.verdict_valid) entries[wr_ptr + RESULT_IDX_BITS'(1)] <= verdict_res;
    end else if (push.verdict_valid) begin
      entries[wr_ptr] <= verdict_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RESULT_IDX_BITS'(n_push);
      if (pop) rd_ptr <= rd_ptr + RESULT_IDX_BITS'(1);
      count  <= count_next;
    end
  end

  assign result.valid       = count != '0;
  assign result.result_kind = entries[rd_ptr].result_kind;
  assign result.name_byte   = entries[rd_ptr].name_byte;
  assign result.verdict     = entries[rd_ptr].verdict;
  assign result.host_length = entries[rd_ptr].host_length;
  assign result.last_of_run = entries[rd_ptr].last_of_run;

endmodule

[rtl/tls_sni_hostname_extractor.sv]
// Each accepted byte's results are registered into the result queue and leave it in order.
// Throughput: one payload byte per cycle while the queue has room; a name's final byte
//   may yield two beats (name byte, then verdict), which drain through a four-entry queue.
// Input ready is high while the queue has room for two results.
// Reset (synchronous, rst high) returns the parser to the record header and empties the queue.
// Top level of the TLS ClientHello server name extractor.
module tls_sni_hostname_extractor #(
  parameter int POSITION_BITS = tsni_pkg::POSITION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  tsni_in_if.sink     payload,
  tsni_out_if.source  result
);
  import tsni_pkg::*;

  parse_out_t parsed;
  logic       room;
  logic       fire;

  assign payload.ready = room;
  assign fire          = payload.valid && room;

  tsni_parser #(.PosBits(POSITION_BITS)) u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (payload.payload_byte),
    .final_byte (payload.end_of_payload),
    .res        (parsed)
  );

  tsni_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (parsed),
    .room   (room),
    .result (result)
  );

endmodule

[rtl/tsni_checker.sv]
// Port-level checks for the extractor, bound to its top level.
module tsni_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [1:0]  verdict,
  input logic [15:0] host_length,
  input logic        last_of_run
);
  import tsni_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(verdict))
    else $error("result beat changed while stalled");

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == RESULT_KIND_VERDICT) == last_of_run)
    else $error("last_of_run does not match verdict beat");

  a_name_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RESULT_KIND_NAME |-> verdict == VERDICT_FOUND &&
      host_length == 16'd0)
    else $error("name beat carries verdict fields");

  a_len_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RESULT_KIND_VERDICT && verdict != VERDICT_FOUND
      |-> host_length == 16'd0)
    else $error("host length set without a found verdict");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind tls_sni_hostname_extractor tsni_checker u_tsni_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .result_kind (result.result_kind),
  .verdict     (result.verdict),
  .host_length (result.host_length),
  .last_of_run (result.last_of_run)
);

[sim/tls_sni_hostname_extractor_test.sv]
// Self-checking testbench for the TLS ClientHello server name extractor.
`timescale 1ns / 100ps

module tls_sni_hostname_extractor_test;
  import tsni_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          MIN_BYTES    = 1400;
  localparam int          MIN_FRAMES   = 12;
  localparam int          REPORT_MAX   = 10;
  localparam logic [7:0]  SSL3_MAJOR   = 8'd3;
  localparam logic [7:0]  SSL3_0_MINOR = 8'd0;

  typedef enum logic [3:0] {
    PH_RECORD_HDR, PH_SID_LEN, PH_SUITES_HI, PH_SUITES_LO, PH_COMP_LEN,
    PH_EXTS_HI, PH_EXTS_LO, PH_EXT_TYPE_HI, PH_EXT_TYPE_LO, PH_EXT_LEN_HI,
    PH_EXT_LEN_LO, PH_NAME_TYPE, PH_NAME_LEN_HI, PH_NAME_LEN_LO, PH_NAME, PH_DONE
  } hello_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } in_beat_t;

  logic clk;
  logic rst;

  tsni_in_if  payload_if ();
  tsni_out_if result_if ();

  tls_sni_hostname_extractor dut (
    .clk     (clk),
    .rst     (rst),
    .payload (payload_if),
    .result  (result_if)
  );

  // Parser tracking state
  logic [16:0]  pos_q, rec_end_q, ext_end_q, sni_end_q, skip_q;
  hello_phase_t phase_q;
  logic [15:0]  len_acc_q, entry_rem_q, found_len_q;
  logic [7:0]   first_q, major_q, minor_q;
  logic         verdict_set_q;
  verdict_t     verdict_q;

  result_t     expected_results[$];
  in_beat_t    pending_beats[$];
  logic [7:0]  frame_q[$];
  in_beat_t    next_beat;
  logic        byte_taken;
  int unsigned send_gap, send_calm, take_stall, take_calm;
  int unsigned mismatch_count, sent_bytes, frame_count, cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_tracker();
    pos_q         = '0;
    rec_end_q     = '0;
    ext_end_q     = '0;
    sni_end_q     = '0;
    skip_q        = '0;
    phase_q       = PH_RECORD_HDR;
    len_acc_q     = '0;
    entry_rem_q   = '0;
    found_len_q   = '0;
    first_q       = '0;
    major_q       = '0;
    minor_q       = '0;
    verdict_set_q = 1'b0;
    verdict_q     = VERDICT_FOUND;
  endfunction

  function automatic void settle(verdict_t v);
    verdict_q     = v;
    verdict_set_q = 1'b1;
    phase_q       = PH_DONE;
  endfunction

  // Skip n bytes, then expect the field of phase nxt; reject if it cannot fit.
  function automatic void skip_then(hello_phase_t nxt, logic [16:0] n);
    logic [17:0] t;
    t = 18'(pos_q) + 18'(n);
    case (nxt)
      PH_SID_LEN, PH_COMP_LEN: begin
        if (t + 18'd1 > 18'(rec_end_q)) begin
          settle(VERDICT_MALFORMED);
          return;
        end
      end
      PH_SUITES_HI: begin
        if (t + 18'd2 > 18'(rec_end_q)) begin
          settle(VERDICT_MALFORMED);
          return;
        end
      end
      PH_EXTS_HI: begin
        // SSL 3.0 hello may legally stop after the compression methods
        if (t == 18'(rec_end_q) && major_q == SSL3_MAJOR && minor_q == SSL3_0_MINOR) begin
          settle(VERDICT_NONAME);
          return;
        end
        if (t + 18'd2 > 18'(rec_end_q)) begin
          settle(VERDICT_MALFORMED);
          return;
        end
      end
      PH_EXT_TYPE_HI: begin
        if (t == 18'(ext_end_q)) begin
          settle(VERDICT_NONAME);
          return;
        end
        if (t + 18'd4 > 18'(ext_end_q)) begin
          settle(VERDICT_MALFORMED);
          return;
        end
      end
      PH_NAME_TYPE: begin
        if (t == 18'(sni_end_q)) begin
          settle(VERDICT_NONAME);
          return;
        end
        if (t + 18'd3 > 18'(sni_end_q)) begin
          settle(VERDICT_MALFORMED);
          return;
        end
      end
      default: ;
    endcase
    phase_q = nxt;
    skip_q  = n;
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic is_last);
    logic [16:0] p;
    logic [15:0] len;
    logic        name_out;
    verdict_t    v;
    result_t     r;
    name_out = 1'b0;
    if (pos_q < 17'(RECORD_HDR_BYTES) || pos_q < rec_end_q) begin
      p     = pos_q;
      pos_q = pos_q + 17'd1;
      if (phase_q != PH_DONE) begin
        if (skip_q != '0) begin
          skip_q = skip_q - 17'd1;
        end else begin
          case (phase_q)
            PH_RECORD_HDR: begin
              if (p == 17'd0) begin
                first_q = b;
              end else if (p == 17'd1) begin
                major_q = b;
              end else if (p == 17'd2) begin
                minor_q = b;
                if ((first_q & SSL2_HELLO_MARK) != 8'h00 && b == SSL2_CLIENT_HELLO)
                  settle(VERDICT_NONAME);
                else if (first_q != TLS_HANDSHAKE)
                  settle(VERDICT_MALFORMED);
                else if (major_q < SSL3_MAJOR)
                  settle(VERDICT_NONAME);
              end else if (p == 17'd3) begin
                len_acc_q = {8'h00, b};
              end else if (p == 17'd4) begin
                rec_end_q = 17'({len_acc_q[7:0], b}) + 17'(RECORD_HDR_BYTES);
                if (rec_end_q < 17'(RECORD_HDR_BYTES + 1)) settle(VERDICT_MALFORMED);
              end else begin
                if (b != HS_CLIENT_HELLO) settle(VERDICT_MALFORMED);
                else skip_then(PH_SID_LEN, 17'(HELLO_FIXED_SKIP));
              end
            end
            PH_SID_LEN: skip_then(PH_SUITES_HI, 17'(b));
            PH_SUITES_HI: begin
              len_acc_q = {8'h00, b};
              phase_q   = PH_SUITES_LO;
            end
            PH_SUITES_LO: skip_then(PH_COMP_LEN, 17'({len_acc_q[7:0], b}));
            PH_COMP_LEN: skip_then(PH_EXTS_HI, 17'(b));
            PH_EXTS_HI: begin
              len_acc_q = {8'h00, b};
              phase_q   = PH_EXTS_LO;
            end
            PH_EXTS_LO: begin
              len = {len_acc_q[7:0], b};
              if (18'(pos_q) + 18'(len) > 18'(rec_end_q)) begin
                settle(VERDICT_MALFORMED);
              end else begin
                ext_end_q = pos_q + 17'(len);
                skip_then(PH_EXT_TYPE_HI, 17'd0);
              end
            end
            PH_EXT_TYPE_HI: begin
              entry_rem_q = {b, 8'h00};
              phase_q     = PH_EXT_TYPE_LO;
            end
            PH_EXT_TYPE_LO: begin
              entry_rem_q[7:0] = b;
              phase_q          = PH_EXT_LEN_HI;
            end
            PH_EXT_LEN_HI: begin
              len_acc_q = {8'h00, b};
              phase_q   = PH_EXT_LEN_LO;
            end
            PH_EXT_LEN_LO: begin
              len = {len_acc_q[7:0], b};
              if (entry_rem_q != 16'd0) begin
                skip_then(PH_EXT_TYPE_HI, 17'(len));
              end else if (18'(pos_q) + 18'(len) > 18'(ext_end_q)) begin
                settle(VERDICT_MALFORMED);
              end else begin
                // server_name: skip the 2-byte list length
                sni_end_q = pos_q + 17'(len);
                skip_then(PH_NAME_TYPE, 17'd2);
              end
            end
            PH_NAME_TYPE: begin
              entry_rem_q = {8'h00, b};
              phase_q     = PH_NAME_LEN_HI;
            end
            PH_NAME_LEN_HI: begin
              len_acc_q = {8'h00, b};
              phase_q   = PH_NAME_LEN_LO;
            end
            PH_NAME_LEN_LO: begin
              len = {len_acc_q[7:0], b};
              if (18'(pos_q) + 18'(len) > 18'(sni_end_q)) begin
                settle(VERDICT_MALFORMED);
              end else if (entry_rem_q[7:0] != NAME_TYPE_HOST) begin
                skip_then(PH_NAME_TYPE, 17'(len));
              end else if (len == 16'd0) begin
                settle(VERDICT_NONAME);
              end else begin
                verdict_q     = VERDICT_FOUND;
                verdict_set_q = 1'b1;
                found_len_q   = len;
                entry_rem_q   = len;
                phase_q       = PH_NAME;
              end
            end
            PH_NAME: begin
              name_out    = 1'b1;
              entry_rem_q = entry_rem_q - 16'd1;
              if (entry_rem_q == 16'd0) phase_q = PH_DONE;
            end
            default: ;
          endcase
        end
      end
    end
    if (name_out) begin
      r             = '0;
      r.result_kind = RESULT_KIND_NAME;
      r.name_byte   = b;
      expected_results.push_back(r);
    end
    if (is_last) begin
      if (pos_q < 17'(RECORD_HDR_BYTES)) v = VERDICT_INCOMPLETE;
      else if (rec_end_q != '0 && pos_q < rec_end_q) v = VERDICT_INCOMPLETE;
      else if (verdict_set_q) v = verdict_q;
      else v = VERDICT_MALFORMED;
      r             = '0;
      r.result_kind = RESULT_KIND_VERDICT;
      r.verdict     = v;
      r.host_length = (v == VERDICT_FOUND) ? found_len_q : 16'd0;
      r.last_of_run = 1'b1;
      expected_results.push_back(r);
      reset_tracker();
    end
  endtask

  // Mostly short idles, a few long ones, and now and then a long run with none.
  function automatic int unsigned pick_idle(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_frame();
    in_beat_t beat;
    foreach (frame_q[i]) begin
      beat.data    = frame_q[i];
      beat.is_last = (i == frame_q.size() - 1);
      pending_beats.push_back(beat);
    end
    sent_bytes  += frame_q.size();
    frame_count += 1;
    frame_q.delete();
  endtask

  // One ClientHello record with random content, sometimes damaged.
  task automatic build_hello();
    logic [7:0]  body[$];
    logic [7:0]  exts[$];
    logic [7:0]  names[$];
    logic [7:0]  minor;
    int unsigned n, k, r, pre, post, has_sni, has_host, rec_len, cut;
    body.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : HS_CLIENT_HELLO);
    repeat (HELLO_FIXED_SKIP) body.push_back(8'($urandom));
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : 0;
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    n = 2 * $urandom_range(1, 6);
    body.push_back(8'(n >> 8));
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    n = $urandom_range(1, 3);
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    minor = 8'($urandom_range(0, 4));

    if ($urandom_range(0, 7) != 0) begin
      pre     = $urandom_range(0, 2);
      post    = $urandom_range(0, 2);
      has_sni = ($urandom_range(0, 9) < 8);
      for (int slot = 0; slot <= pre + post; slot++) begin
        if (slot == pre && has_sni) begin
          names.delete();
          has_host = ($urandom_range(0, 9) < 8);
          pre      = $urandom_range(0, 2);
          post     = $urandom_range(0, 1);
          for (int j = 0; j <= pre + post; j++) begin
            if (j == pre && has_host) begin
              r = $urandom_range(0, 99);
              if (r < 8) n = 0;
              else if (r < 12) n = $urandom_range(100, 200);
              else n = $urandom_range(1, 24);
              names.push_back(NAME_TYPE_HOST);
              names.push_back(8'(n >> 8));
              names.push_back(8'(n));
              repeat (n) begin
                if ($urandom_range(0, 9) == 0) names.push_back(8'($urandom));
                else names.push_back(8'($urandom_range(8'h61, 8'h7a)));
              end
            end else begin
              n = $urandom_range(0, 5);
              names.push_back(8'($urandom_range(1, 255)));
              names.push_back(8'(n >> 8));
              names.push_back(8'(n));
              repeat (n) names.push_back(8'($urandom));
            end
          end
          n = names.size();
          exts.push_back(8'h00);
          exts.push_back(8'h00);
          exts.push_back(8'((n + 2) >> 8));
          exts.push_back(8'(n + 2));
          exts.push_back(8'(n >> 8));
          exts.push_back(8'(n));
          foreach (names[i]) exts.push_back(names[i]);
        end else begin
          k = $urandom_range(1, 65535);
          n = $urandom_range(0, 6);
          exts.push_back(8'(k >> 8));
          exts.push_back(8'(k));
          exts.push_back(8'(n >> 8));
          exts.push_back(8'(n));
          repeat (n) exts.push_back(8'($urandom));
        end
      end
      body.push_back(8'(exts.size() >> 8));
      body.push_back(8'(exts.size()));
      foreach (exts[i]) body.push_back(exts[i]);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
    end

    if ($urandom_range(0, 99) < 15) body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
    rec_len = body.size();
    if ($urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 1)) rec_len = rec_len + $urandom_range(1, 8);
      else rec_len = rec_len - $urandom_range(1, 8);
    end

    frame_q.push_back(TLS_HANDSHAKE);
    frame_q.push_back(SSL3_MAJOR);
    frame_q.push_back(minor);
    frame_q.push_back(8'(rec_len >> 8));
    frame_q.push_back(8'(rec_len));
    foreach (body[i]) frame_q.push_back(body[i]);
    if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    queue_frame();
  endtask

  // Source side: present the next byte once the previous one is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (!payload_if.valid || byte_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          payload_if.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          next_beat = pending_beats.pop_front();
          payload_if.payload_byte   <= next_beat.data;
          payload_if.end_of_payload <= next_beat.is_last;
          payload_if.valid          <= 1'b1;
          send_gap = pick_idle(send_calm);
        end else begin
          payload_if.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random backpressure on result beats.
  always @(negedge clk) begin
    if (!rst) begin
      if (take_stall > 0) begin
        take_stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        take_stall = pick_idle(take_calm);
      end
    end
  end

  // Result beats are checked before the byte taken at the same edge is tracked.
  always @(posedge clk) begin
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result beat: kind %0d byte %02h verdict %0d len %0d last %0d",
                     result_if.result_kind, result_if.name_byte, result_if.verdict,
                     result_if.host_length, result_if.last_of_run);
        end else begin
          result_t want;
          want = expected_results.pop_front();
          if (result_if.result_kind !== want.result_kind ||
              result_if.name_byte   !== want.name_byte ||
              result_if.verdict     !== want.verdict ||
              result_if.host_length !== want.host_length ||
              result_if.last_of_run !== want.last_of_run) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("result mismatch: got kind %0d byte %02h verdict %0d len %0d last %0d, %s",
                       result_if.result_kind, result_if.name_byte, result_if.verdict,
                       result_if.host_length, result_if.last_of_run,
                       $sformatf("want kind %0d byte %02h verdict %0d len %0d last %0d",
                                 want.result_kind, want.name_byte, want.verdict,
                                 want.host_length, want.last_of_run));
          end
        end
      end
      byte_taken = payload_if.valid && payload_if.ready;
      if (byte_taken) track_byte(payload_if.payload_byte, payload_if.end_of_payload);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tls_sni_hostname_extractor test failed");
    $finish;
  end

  initial begin
    int unsigned n;
    rst                       = 1'b1;
    payload_if.valid          = 1'b0;
    payload_if.payload_byte   = 8'h00;
    payload_if.end_of_payload = 1'b0;
    result_if.ready           = 1'b0;
    byte_taken                = 1'b0;
    send_gap                  = 0;
    send_calm                 = 0;
    take_stall                = 0;
    take_calm                 = 0;
    mismatch_count            = 0;
    sent_bytes                = 0;
    frame_count               = 0;
    reset_tracker();

    // header corner cases: short, SSL2, wrong type, old version, empty and huge record
    frame_q = {TLS_HANDSHAKE};
    queue_frame();
    frame_q = {TLS_HANDSHAKE, SSL3_MAJOR, 8'h01};
    queue_frame();
    frame_q = {8'h80, 8'h2e, SSL2_CLIENT_HELLO, 8'h00, 8'h02};
    queue_frame();
    frame_q = {8'h17, SSL3_MAJOR, 8'h03, 8'h00, 8'h05};
    queue_frame();
    frame_q = {TLS_HANDSHAKE, 8'h02, 8'h00, 8'h00, 8'h10};
    queue_frame();
    frame_q = {TLS_HANDSHAKE, SSL3_MAJOR, 8'h01, 8'h00, 8'h00};
    queue_frame();
    frame_q = {TLS_HANDSHAKE, SSL3_MAJOR, 8'h03, 8'hff, 8'hff, HS_CLIENT_HELLO};
    queue_frame();

    while (sent_bytes < MIN_BYTES || frame_count < MIN_FRAMES) begin
      if ($urandom_range(0, 9) < 7) begin
        build_hello();
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) frame_q.push_back(8'($urandom));
        if ($urandom_range(0, 1)) frame_q[0] = TLS_HANDSHAKE;
        if (n >= 3 && $urandom_range(0, 3) == 0) begin
          frame_q[0] = frame_q[0] | SSL2_HELLO_MARK;
          frame_q[2] = SSL2_CLIENT_HELLO;
        end
        queue_frame();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sampled at the rising edge, where the source side is settled
    while (pending_beats.size() != 0 || payload_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tls_sni_hostname_extractor test passed");
    else
      $display("tls_sni_hostname_extractor test failed");
    $finish;
  end

endmodule
